// File: hdl/aunp_pkg.sv
package aunp_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ZERO = 3'd1,
        MODE_DEC  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_BIN  = 3'd4
    } t_mode;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVER_32   = 2'd1;
    localparam logic [1:0] STATUS_OVER_WIDTH = 2'd2;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned SUM_W   = VALUE_W + 4;

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_B   = 8'h62;
    localparam logic [7:0] CHAR_LOW_F   = 8'h66;
    localparam logic [7:0] CHAR_LOW_X   = 8'h78;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } t_digit;

endpackage

// File: hdl/aunp_if.sv
interface aunp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic [5:0] field_width;

    modport source (output valid, output char_in, output field_width, input ready);
    modport sink   (input valid, input char_in, input field_width, output ready);
endinterface

interface aunp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] number_value;
    logic [1:0]  status;
    logic        no_digits;

    modport source (output valid, output number_value, output status, output no_digits,
                    input ready);
    modport sink   (input valid, input number_value, input status, input no_digits,
                    output ready);
endinterface

// File: hdl/aunp_digit.sv
module aunp_digit (
    input  logic [7:0]     i_char,
    input  aunp_pkg::t_mode i_mode,
    output aunp_pkg::t_digit o_digit
);
    import aunp_pkg::*;

    logic [7:0] w_dec_off;
    logic [7:0] w_up_off;
    logic [7:0] w_low_off;

    assign w_dec_off = i_char - CHAR_ZERO;
    assign w_up_off  = i_char - CHAR_UP_A + 8'd10;
    assign w_low_off = i_char - CHAR_LOW_A + 8'd10;

    always_comb begin
        o_digit = '0;
        case (i_mode)
            MODE_BIN: begin
                if (i_char inside {CHAR_ZERO, CHAR_ONE}) begin
                    o_digit.hit   = 1'b1;
                    o_digit.value = w_dec_off[3:0];
                end
            end
            MODE_HEX: begin
                if (i_char inside {[CHAR_ZERO:CHAR_NINE]}) begin
                    o_digit.hit   = 1'b1;
                    o_digit.value = w_dec_off[3:0];
                end else if (i_char inside {[CHAR_UP_A:CHAR_UP_F]}) begin
                    o_digit.hit   = 1'b1;
                    o_digit.value = w_up_off[3:0];
                end else if (i_char inside {[CHAR_LOW_A:CHAR_LOW_F]}) begin
                    o_digit.hit   = 1'b1;
                    o_digit.value = w_low_off[3:0];
                end
            end
            default: begin
                if (i_char inside {[CHAR_ZERO:CHAR_NINE]}) begin
                    o_digit.hit   = 1'b1;
                    o_digit.value = w_dec_off[3:0];
                end
            end
        endcase
    end

endmodule

// File: hdl/ascii_unsigned_number_parser.sv
// A result appears in the output register in the cycle after the item that ends a number.
// Throughput: one item per cycle; the input is taken whenever the output register is empty
// or is being drained in the same cycle.
// All per-item work (digit decode, constant multiply-add, width check) is combinational logic.
// Reset (i_rst_n low, synchronous) returns the parser to whitespace skipping with an empty
// accumulator and drops any pending result.
module ascii_unsigned_number_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aunp_in_if.sink    i_in,
    aunp_out_if.source o_out
);
    import aunp_pkg::*;

    t_mode            r_mode, n_mode;
    logic [31:0]      r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic             r_digit, n_digit;

    logic             r_out_valid;
    logic [31:0]      r_out_value;
    logic [1:0]       r_out_status;
    logic             r_out_empty;

    logic             w_accept;
    logic             w_finish;
    logic             w_space;
    t_digit           w_digit;
    logic [SUM_W-1:0] w_scaled;
    logic [SUM_W-1:0] w_sum;
    logic             w_wide_fail;
    logic [1:0]       w_status;

    aunp_digit u_digit (
        .i_char  (i_in.char_in),
        .i_mode  (r_mode),
        .o_digit (w_digit)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_space    = (i_in.char_in == CHAR_TAB) || (i_in.char_in == CHAR_NL)
                     || (i_in.char_in == CHAR_SPACE);

    // acc * base + digit, kept 4 bits wider to see the carry past 32 bits
    always_comb begin
        case (r_mode)
            MODE_HEX: w_scaled = {r_acc, 4'b0000};
            MODE_BIN: w_scaled = {3'b000, r_acc, 1'b0};
            default:  w_scaled = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
        endcase
        w_sum = w_scaled + {{(SUM_W-4){1'b0}}, w_digit.value};
    end

    assign w_wide_fail = !i_in.field_width[5] && ((r_acc >> i_in.field_width[4:0]) != '0);
    assign w_status    = r_ovf ? STATUS_OVER_32 : (w_wide_fail ? STATUS_OVER_WIDTH : STATUS_OK);

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_digit  = r_digit;
        w_finish = 1'b0;
        if (w_accept) begin
            case (r_mode)
                MODE_IDLE: begin
                    if (w_space) begin
                        n_mode = MODE_IDLE;
                    end else if (i_in.char_in == CHAR_ZERO) begin
                        n_mode  = MODE_ZERO;
                        n_acc   = '0;
                        n_digit = 1'b1;
                    end else if (w_digit.hit) begin
                        n_mode  = MODE_DEC;
                        n_acc   = w_sum[31:0];
                        n_ovf   = r_ovf || (w_sum[SUM_W-1:32] != '0);
                        n_digit = 1'b1;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                MODE_ZERO: begin
                    if (i_in.char_in == CHAR_LOW_X) begin
                        n_mode  = MODE_HEX;
                        n_digit = 1'b0;
                    end else if (i_in.char_in == CHAR_LOW_B) begin
                        n_mode  = MODE_BIN;
                        n_digit = 1'b0;
                    end else if (w_digit.hit) begin
                        n_mode  = MODE_DEC;
                        n_acc   = w_sum[31:0];
                        n_ovf   = r_ovf || (w_sum[SUM_W-1:32] != '0);
                        n_digit = 1'b1;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                default: begin
                    if (w_digit.hit) begin
                        n_acc   = w_sum[31:0];
                        n_ovf   = r_ovf || (w_sum[SUM_W-1:32] != '0);
                        n_digit = 1'b1;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
            endcase
            if (w_finish) begin
                n_mode  = MODE_IDLE;
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_digit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_digit <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_digit <= n_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the payload until the next finished number is loaded
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_value  <= r_acc;
            r_out_status <= w_status;
            r_out_empty  <= !r_digit;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.number_value = r_out_value;
    assign o_out.status       = r_out_status;
    assign o_out.no_digits    = r_out_empty;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_mode == MODE_IDLE) && !r_out_valid)
        else $error("parser not cleared by reset");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> (r_acc == '0) && !r_ovf && !r_digit)
        else $error("idle with leftover number state");

    a_zero_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ZERO) |-> (r_acc == '0) && r_digit && !r_ovf)
        else $error("leading zero state inconsistent");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_valid && (r_mode == MODE_IDLE))
        else $error("finished number not presented");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_value == '0) && (r_out_status == STATUS_OK))
        else $error("empty number with nonzero value or status");

endmodule
